// ===== design/cspb_pkg.sv =====
// Shared types, constants and helper functions for the clipped sprite blit.
// No dependencies; every other design file refers to this package by scoped names.
package cspb_pkg;

	localparam int MaxDim = 4096;
	localparam int SizeW  = 13;
	localparam int CntW   = $clog2(MaxDim);
	localparam int AddrW  = 24;
	localparam int PixW   = 32;

	typedef enum logic [2:0] {
		REG_SCREEN_W = 3'd0,
		REG_SCREEN_H = 3'd1,
		REG_TEX_W    = 3'd2,
		REG_TEX_H    = 3'd3,
		REG_POS_X    = 3'd4,
		REG_POS_Y    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [SizeW-1:0]        screen_width;
		logic [SizeW-1:0]        screen_height;
		logic [SizeW-1:0]        tex_width;
		logic [SizeW-1:0]        tex_height;
		logic signed [SizeW-1:0] pos_x;
		logic signed [SizeW-1:0] pos_y;
	} cfg_t;

	// Work carried from the walk stage to the output stage.
	typedef struct packed {
		logic            we;
		logic [CntW-1:0] sx;
		logic [CntW-1:0] sy;
		logic            last;
		logic [PixW-1:0] tex;
		logic [PixW-1:0] back;
	} s1_t;

	// A size of zero acts as one; anything above the maximum acts as the maximum.
	function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v);
		logic [SizeW-1:0] r;
		r = v;
		if (v == '0) begin
			r = SizeW'(1);
		end else if (v > SizeW'(MaxDim)) begin
			r = SizeW'(MaxDim);
		end
		return r;
	endfunction

	// dst + floor(alpha * (src - dst) / 256), kept to eight bits.
	function automatic logic [7:0] blend_byte(input logic [7:0] s, input logic [7:0] d,
			input logic [7:0] a);
		logic signed [8:0]  diff;
		logic signed [17:0] prod;
		diff = $signed({1'b0, s}) - $signed({1'b0, d});
		prod = $signed({10'b0, a}) * 18'(diff);
		return d + prod[15:8];
	endfunction

endpackage

// ===== design/clipped_sprite_alpha_blit.sv =====
// Clipped sprite blit with alpha blending, top level.
// Each input transfer is registered in the walk stage and then in the output stage before its result is valid.
// Throughput: one texel per cycle; both stages hold while the output is stalled.
// Reset clears the counters and valid flags, sizes to 1 and positions to 0.
// Instantiates cspb_cfg, cspb_walk and cspb_out; depends on cspb_pkg.
module clipped_sprite_alpha_blit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [cspb_pkg::SizeW-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [cspb_pkg::PixW-1:0]  tex_pixel,
	input  logic [cspb_pkg::PixW-1:0]  back_pixel,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       write_enable,
	output logic [cspb_pkg::AddrW-1:0] pixel_address,
	output logic [cspb_pkg::PixW-1:0]  pixel_value,
	output logic                       last
);

	cspb_pkg::cfg_t cfg;
	cspb_pkg::s1_t  s1;
	logic           s1_valid;
	logic           s2_take;

	cspb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cspb_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.tex_pixel  (tex_pixel),
		.back_pixel (back_pixel),
		.s2_take    (s2_take),
		.s1_valid   (s1_valid),
		.s1         (s1)
	);

	cspb_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.s1_valid      (s1_valid),
		.s1            (s1),
		.s2_take       (s2_take),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_enable  (write_enable),
		.pixel_address (pixel_address),
		.pixel_value   (pixel_value),
		.last          (last)
	);

endmodule

// ===== design/cspb_cfg.sv =====
// Configuration register bank of the clipped sprite blit.
// Depends on cspb_pkg for the register indexes, the cfg_t type and size clamping.
module cspb_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [cspb_pkg::SizeW-1:0] cfg_data,
	output cspb_pkg::cfg_t             cfg
);

	cspb_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= cspb_pkg::SizeW'(1);
			cfg_q.screen_height <= cspb_pkg::SizeW'(1);
			cfg_q.tex_width     <= cspb_pkg::SizeW'(1);
			cfg_q.tex_height    <= cspb_pkg::SizeW'(1);
			cfg_q.pos_x         <= '0;
			cfg_q.pos_y         <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				cspb_pkg::REG_SCREEN_W: cfg_q.screen_width  <= cspb_pkg::clamp_size(cfg_data);
				cspb_pkg::REG_SCREEN_H: cfg_q.screen_height <= cspb_pkg::clamp_size(cfg_data);
				cspb_pkg::REG_TEX_W:    cfg_q.tex_width     <= cspb_pkg::clamp_size(cfg_data);
				cspb_pkg::REG_TEX_H:    cfg_q.tex_height    <= cspb_pkg::clamp_size(cfg_data);
				cspb_pkg::REG_POS_X:    cfg_q.pos_x         <= $signed(cfg_data);
				cspb_pkg::REG_POS_Y:    cfg_q.pos_y         <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/cspb_walk.sv =====
// Input stage: texel column/row counters, screen placement and clipping.
// Depends on cspb_pkg for cfg_t, s1_t and the width constants.
module cspb_walk (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cspb_pkg::cfg_t            cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [cspb_pkg::PixW-1:0] tex_pixel,
	input  logic [cspb_pkg::PixW-1:0] back_pixel,
	input  logic                      s2_take,
	output logic                      s1_valid,
	output cspb_pkg::s1_t             s1
);

	localparam int CntW = cspb_pkg::CntW;
	localparam int SizeW = cspb_pkg::SizeW;

	logic [CntW-1:0]    col_q, row_q;
	logic               valid_s1;
	cspb_pkg::s1_t      data_s1;
	logic               accept;
	logic signed [SizeW:0] sx, sy;
	logic               on_x, on_y;
	logic               col_end, row_end;

	assign in_ready = !valid_s1 || s2_take;
	assign accept   = in_valid && in_ready;

	// Screen coordinates are one bit wider than the position so a negative sum is seen.
	assign sx = (SizeW+1)'(cfg.pos_x) + $signed({2'b0, col_q});
	assign sy = (SizeW+1)'(cfg.pos_y) + $signed({2'b0, row_q});
	assign on_x = !sx[SizeW] && (sx[SizeW-1:0] < cfg.screen_width);
	assign on_y = !sy[SizeW] && (sy[SizeW-1:0] < cfg.screen_height);

	assign col_end = ({1'b0, col_q} + SizeW'(1)) >= cfg.tex_width;
	assign row_end = ({1'b0, row_q} + SizeW'(1)) >= cfg.tex_height;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_q + CntW'(1);
				end else begin
					col_q <= col_q + CntW'(1);
				end
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1.we   <= on_x && on_y && (tex_pixel[31:24] != 8'd0);
			data_s1.sx   <= sx[CntW-1:0];
			data_s1.sy   <= sy[CntW-1:0];
			data_s1.last <= col_end && row_end;
			data_s1.tex  <= tex_pixel;
			data_s1.back <= back_pixel;
		end
	end

	assign s1_valid = valid_s1;
	assign s1       = data_s1;

endmodule

// ===== design/cspb_out.sv =====
// Output stage: screen address, copy or alpha blend, and the result register.
// Depends on cspb_pkg for cfg_t, s1_t, widths and the blend function.
module cspb_out (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cspb_pkg::cfg_t             cfg,
	input  logic                       s1_valid,
	input  cspb_pkg::s1_t              s1,
	output logic                       s2_take,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       write_enable,
	output logic [cspb_pkg::AddrW-1:0] pixel_address,
	output logic [cspb_pkg::PixW-1:0]  pixel_value,
	output logic                       last
);

	localparam int AddrW = cspb_pkg::AddrW;
	localparam int PixW  = cspb_pkg::PixW;
	localparam int ProdW = cspb_pkg::CntW + cspb_pkg::SizeW;

	logic             valid_q;
	logic             we_q, last_q;
	logic [AddrW-1:0] addr_q;
	logic [PixW-1:0]  value_q;
	logic [ProdW-1:0] row_base;
	logic [AddrW-1:0] addr;
	logic [PixW-1:0]  blended, value;

	assign s2_take = s1_valid && (!valid_q || out_ready);

	assign row_base = ProdW'(s1.sy) * ProdW'(cfg.screen_width);
	assign addr     = row_base[AddrW-1:0] + AddrW'(s1.sx);

	// Partial alpha blends the color bytes and keeps the screen pixel's alpha.
	assign blended = {s1.back[31:24],
		cspb_pkg::blend_byte(s1.tex[23:16], s1.back[23:16], s1.tex[31:24]),
		cspb_pkg::blend_byte(s1.tex[15:8],  s1.back[15:8],  s1.tex[31:24]),
		cspb_pkg::blend_byte(s1.tex[7:0],   s1.back[7:0],   s1.tex[31:24])};
	assign value = (s1.tex[31:24] == 8'hFF) ? s1.tex : blended;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_take) begin
			we_q    <= s1.we;
			last_q  <= s1.last;
			addr_q  <= s1.we ? addr : '0;
			value_q <= s1.we ? value : '0;
		end
	end

	assign out_valid     = valid_q;
	assign write_enable  = we_q;
	assign last          = last_q;
	assign pixel_address = addr_q;
	assign pixel_value   = value_q;

endmodule
